@@ design/ssrg_pkg.sv @@
package ssrg_pkg;

   // Field widths of a request
   localparam int unsigned PORT_W  = 4;
   localparam int unsigned IDENT_W = 4;
   localparam int unsigned ROLE_W  = 2;
   localparam int unsigned SESS_W  = 16;
   localparam int unsigned SEQ_W   = 32;
   localparam int unsigned KEY_W   = PORT_W + IDENT_W + ROLE_W + SESS_W;
   // Source part of the key: port, identity and role
   localparam int unsigned SRC_W   = PORT_W + IDENT_W + ROLE_W;

   typedef enum logic [1:0] {
      REQ_EVALUATE      = 2'd0,
      REQ_RESET_SESSION = 2'd1,
      REQ_RESET_SOURCE  = 2'd2,
      REQ_RESET_ALL     = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED       = 3'd0,
      ST_NOT_INCREASING = 3'd1,
      ST_TABLE_FULL     = 3'd2,
      ST_CLEARED        = 3'd3,
      ST_NOT_FOUND      = 3'd4,
      ST_RESET_DONE     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE
   } fsm_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [SEQ_W-1:0] seq;
   } entry_type;

endpackage

@@ design/ssrg_entry_mem.sv @@
module ssrg_entry_mem
   import ssrg_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output entry_type        rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/session_sequence_replay_guard.sv @@
// Every request but reset-all is worked on in a scan of the table and a decide
// step before its response; a reset-all request is answered at the very next edge.
// A new request is taken only once busy has dropped; the pace is set by the scan, which reads
// one table entry per cycle through the single read port and one key compare.
// Reset: synchronous; every entry is invalid and no response is pending.
// The receiver cannot stall: each response shows for exactly one cycle.
module session_sequence_replay_guard
   import ssrg_pkg::*;
#(
   parameter int unsigned SESSIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [PORT_W-1:0]   req_ingress_port,
   input  logic [IDENT_W-1:0]  req_link_identity,
   input  logic [ROLE_W-1:0]   req_link_role,
   input  logic [SESS_W-1:0]   req_session_id,
   input  logic [SEQ_W-1:0]    req_sequence_number,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status
);

   localparam int unsigned IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam logic [IW:0]   SCAN_END = (IW+1)'(SESSIONS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SESSIONS - 1);

   fsm_type            state_ff, state_in;
   logic               valid_ff [SESSIONS];
   req_kind_type       kind_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [IW:0]        rd_cnt_ff;
   logic               chk_live_ff;
   logic [IW-1:0]      chk_idx_ff;
   logic               found_ff;
   logic [IW-1:0]      match_idx_ff;
   logic [SEQ_W-1:0]   match_seq_ff;
   logic               free_ff;
   logic [IW-1:0]      free_idx_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;

   logic               accept;
   logic               rd_en;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   entry_type          wr_data;
   entry_type          rd_data;
   logic               chk_valid;
   logic               hit_full;
   logic               hit_src;
   logic               scan_done;
   logic               seq_greater;
   logic               set_valid;
   logic               clr_match;
   status_type         decide_status;

   ssrg_entry_mem #(
      .DEPTH (SESSIONS),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign accept = start && (state_ff == FSM_IDLE);
   assign busy   = (state_ff != FSM_IDLE);

   // Compare the entry read last cycle against the held key
   assign chk_valid   = valid_ff[chk_idx_ff];
   assign hit_full    = chk_live_ff && chk_valid && (rd_data.key == key_ff);
   assign hit_src     = chk_live_ff && chk_valid &&
                        (rd_data.key[KEY_W-1 -: SRC_W] == key_ff[KEY_W-1 -: SRC_W]);
   assign scan_done   = chk_live_ff && (chk_idx_ff == LAST_IDX);
   assign seq_greater = (seq_ff > match_seq_ff);

   // Sequencer: next state and decision outputs
   always_comb begin
      state_in      = state_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = match_idx_ff;
      set_valid     = 1'b0;
      clr_match     = 1'b0;
      decide_status = ST_RESET_DONE;
      wr_data.key   = key_ff;
      wr_data.seq   = seq_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept && (req_kind_type'(req_type) != REQ_RESET_ALL)) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            rd_en = (rd_cnt_ff < SCAN_END);
            if (scan_done) begin
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: begin
            state_in = FSM_IDLE;
            unique case (kind_ff)
               REQ_EVALUATE: begin
                  if (found_ff) begin
                     if (seq_greater) begin
                        wr_en         = 1'b1;
                        decide_status = ST_ACCEPTED;
                     end else begin
                        decide_status = ST_NOT_INCREASING;
                     end
                  end else if (free_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = free_idx_ff;
                     set_valid     = 1'b1;
                     decide_status = ST_ACCEPTED;
                  end else begin
                     decide_status = ST_TABLE_FULL;
                  end
               end
               REQ_RESET_SESSION: begin
                  if (found_ff) begin
                     clr_match     = 1'b1;
                     decide_status = ST_CLEARED;
                  end else begin
                     decide_status = ST_NOT_FOUND;
                  end
               end
               REQ_RESET_SOURCE: decide_status = ST_RESET_DONE;
               REQ_RESET_ALL:    decide_status = ST_RESET_DONE;
               default:          decide_status = ST_RESET_DONE;
            endcase
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the request while it is worked on
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind_type'(req_type);
         key_ff  <= {req_ingress_port, req_link_identity, req_link_role, req_session_id};
         seq_ff  <= req_sequence_number;
      end
   end

   // Advance the scan: read pointer and check stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff   <= '0;
         chk_live_ff <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
      end else if (accept) begin
         rd_cnt_ff   <= '0;
         chk_live_ff <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
      end else if (state_ff == FSM_SCAN) begin
         if (rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
         chk_live_ff <= rd_en;
         if (!found_ff && hit_full) begin
            found_ff <= 1'b1;
         end
         if (!free_ff && chk_live_ff && !chk_valid) begin
            free_ff <= 1'b1;
         end
      end
   end

   // Capture the first match and the lowest free entry
   always_ff @(posedge clock) begin
      if (state_ff == FSM_SCAN) begin
         chk_idx_ff <= rd_cnt_ff[IW-1:0];
         if (!found_ff && hit_full) begin
            match_idx_ff <= chk_idx_ff;
            match_seq_ff <= rd_data.seq;
         end
         if (!free_ff && chk_live_ff && !chk_valid) begin
            free_idx_ff <= chk_idx_ff;
         end
      end
   end

   // Valid bits: drop on reset-all, source match or session clear; set on allocation
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SESSIONS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (accept && (req_kind_type'(req_type) == REQ_RESET_ALL)) begin
         for (int i = 0; i < SESSIONS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if ((state_ff == FSM_SCAN) && (kind_ff == REQ_RESET_SOURCE) && hit_src) begin
            valid_ff[chk_idx_ff] <= 1'b0;
         end
         if (set_valid) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (clr_match) begin
            valid_ff[match_idx_ff] <= 1'b0;
         end
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == FSM_DECIDE) ||
                         (accept && (req_kind_type'(req_type) == REQ_RESET_ALL));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FSM_DECIDE) begin
         rsp_status_ff <= decide_status;
      end else if (accept) begin
         rsp_status_ff <= ST_RESET_DONE;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ design/ssrg_checker.sv @@
module ssrg_checker
   import ssrg_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic [2:0] rsp_status
);

   // Status codes stay within the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_RESET_DONE))
      else $error("status code out of range");

   // Reset-all answers in the next cycle with reset done
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_RESET_ALL))
      |=> (rsp_valid && (rsp_status == ST_RESET_DONE) && !busy))
      else $error("reset-all response missing");

   // Any other request occupies the block
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type != REQ_RESET_ALL)) |=> (busy && !rsp_valid))
      else $error("request not taken into the scan");

   // A response only appears once the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // No response straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind session_sequence_replay_guard ssrg_checker u_ssrg_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_type   (req_type),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);
